@@ rtl/core/terr_pkg.sv @@
// shared types and codes for the timed event record and replay block
package terr_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_EVENT  = 2'd1,
        OP_RECORD = 2'd2,
        OP_PLAY   = 2'd3
    } t_opcode;

    localparam int unsigned DELAY_W = 32;
    localparam int unsigned STAT_W  = 8;

    typedef struct packed {
        logic [7:0]         buttons;
        logic signed [7:0]  dx;
        logic signed [7:0]  dy;
        logic signed [7:0]  wheel;
        logic [DELAY_W-1:0] delay;
    } t_entry;

endpackage

@@ rtl/core/terr_store.sv @@
// event store: one write port, one read port, registered read data
module terr_store #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  terr_pkg::t_entry           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output terr_pkg::t_entry           o_rdata
);
    import terr_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/timed_event_record_replay.sv @@
// top level of the timed event record and replay block
// Records pointer events with the tick delay since the previous event or recording
// start into a store of DEPTH entries and replays them in an endless loop. Every input
// item gives one result item. A playback tick reads the store entry at the play position
// when taken, then compares its delay and updates the play state in S_TICK; any other
// item finishes when taken. One item is in work at a time, and a new item is taken while
// the result register is empty or being drained. The store has no reset and needs no
// clearing pass: playback only reads entries written since recording last started.
module timed_event_record_replay #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_ev_buttons,
    input  logic signed [7:0]      i_ev_dx,
    input  logic signed [7:0]      i_ev_dy,
    input  logic signed [7:0]      i_ev_wheel,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_report_valid,
    output logic [7:0]             o_out_buttons,
    output logic signed [7:0]      o_out_dx,
    output logic signed [7:0]      o_out_dy,
    output logic signed [7:0]      o_out_wheel,
    output logic                   o_is_recording,
    output logic                   o_is_playing,
    output logic [terr_pkg::STAT_W-1:0] o_events_stored
);
    import terr_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic {S_IDLE, S_TICK} t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_recording, n_recording;
    logic                 r_playing, n_playing;
    logic [PW-1:0]        r_play_pos, n_play_pos;
    logic [PW-1:0]        r_rd_pos, n_rd_pos;
    logic [DELAY_W-1:0]   r_time, n_time;
    logic [DELAY_W-1:0]   r_rec_mark, n_rec_mark;
    logic [DELAY_W-1:0]   r_play_mark, n_play_mark;

    logic                 r_o_valid, n_o_valid;
    logic                 r_report, n_report;
    logic [7:0]           r_buttons, n_buttons;
    logic signed [7:0]    r_dx, n_dx;
    logic signed [7:0]    r_dy, n_dy;
    logic signed [7:0]    r_wheel, n_wheel;
    logic                 r_o_rec, n_o_rec;
    logic                 r_o_play, n_o_play;
    logic [CW-1:0]        r_o_count, n_o_count;

    logic                 accept;
    logic                 we, re;
    logic [PW-1:0]        raddr;
    t_entry               wdata, rdata;
    logic [PW-1:0]        clamp_pos;
    logic [CW-1:0]        pos_inc;
    logic [CW+STAT_W-1:0] count_ext;
    t_opcode              op;

    terr_store #(.DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[PW-1:0]),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_stall = (r_state != S_IDLE) || (r_o_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign op      = t_opcode'(i_opcode);

    // play position falls back to the first entry once it runs past the count
    assign clamp_pos = (CW'(r_play_pos) >= r_count) ? '0 : r_play_pos;
    assign pos_inc   = CW'(r_rd_pos) + CW'(1);
    assign raddr     = clamp_pos;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_recording = r_recording;
        n_playing   = r_playing;
        n_play_pos  = r_play_pos;
        n_rd_pos    = r_rd_pos;
        n_time      = r_time;
        n_rec_mark  = r_rec_mark;
        n_play_mark = r_play_mark;
        n_o_valid   = r_o_valid && i_stall;
        n_report    = r_report;
        n_buttons   = r_buttons;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_wheel     = r_wheel;
        n_o_rec     = r_o_rec;
        n_o_play    = r_o_play;
        n_o_count   = r_o_count;
        we          = 1'b0;
        re          = 1'b0;
        wdata       = '{buttons: i_ev_buttons, dx: i_ev_dx, dy: i_ev_dy, wheel: i_ev_wheel,
                        delay: r_time - r_rec_mark};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_TICK: begin
                            n_time = r_time + DELAY_W'(1);
                            if (r_playing && r_count != '0) begin
                                re       = 1'b1;
                                n_rd_pos = clamp_pos;
                                n_state  = S_TICK;
                            end
                        end
                        OP_EVENT: begin
                            if (r_recording && !r_playing && r_count < CW'(DEPTH)) begin
                                we         = 1'b1;
                                n_rec_mark = r_time;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_RECORD: begin
                            if (r_recording) begin
                                n_recording = 1'b0;
                            end else begin
                                n_count     = '0;
                                n_recording = 1'b1;
                                n_playing   = 1'b0;
                                n_rec_mark  = r_time;
                            end
                        end
                        OP_PLAY: begin
                            if (!r_recording && r_count != '0) begin
                                if (!r_playing) begin
                                    n_playing   = 1'b1;
                                    n_play_pos  = '0;
                                    n_play_mark = r_time;
                                end else begin
                                    n_playing = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    // everything but a playback tick finishes here
                    if (n_state == S_IDLE) begin
                        n_o_valid = 1'b1;
                        n_report  = 1'b0;
                        n_buttons = '0;
                        n_dx      = '0;
                        n_dy      = '0;
                        n_wheel   = '0;
                        n_o_rec   = n_recording;
                        n_o_play  = n_playing;
                        n_o_count = n_count;
                    end
                end
            end
            S_TICK: begin
                if (!r_o_valid || !i_stall) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    n_o_rec   = r_recording;
                    n_o_play  = r_playing;
                    n_o_count = r_count;
                    if ((r_time - r_play_mark) >= rdata.delay) begin
                        n_report    = 1'b1;
                        n_buttons   = rdata.buttons;
                        n_dx        = rdata.dx;
                        n_dy        = rdata.dy;
                        n_wheel     = rdata.wheel;
                        n_play_mark = r_time;
                        n_play_pos  = (pos_inc >= r_count) ? '0 : pos_inc[PW-1:0];
                    end else begin
                        n_report   = 1'b0;
                        n_buttons  = '0;
                        n_dx       = '0;
                        n_dy       = '0;
                        n_wheel    = '0;
                        n_play_pos = r_rd_pos;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_recording <= 1'b0;
            r_playing   <= 1'b0;
            r_play_pos  <= '0;
            r_rd_pos    <= '0;
            r_time      <= '0;
            r_rec_mark  <= '0;
            r_play_mark <= '0;
            r_o_valid   <= 1'b0;
            r_report    <= 1'b0;
            r_buttons   <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_wheel     <= '0;
            r_o_rec     <= 1'b0;
            r_o_play    <= 1'b0;
            r_o_count   <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_recording <= n_recording;
            r_playing   <= n_playing;
            r_play_pos  <= n_play_pos;
            r_rd_pos    <= n_rd_pos;
            r_time      <= n_time;
            r_rec_mark  <= n_rec_mark;
            r_play_mark <= n_play_mark;
            r_o_valid   <= n_o_valid;
            r_report    <= n_report;
            r_buttons   <= n_buttons;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_wheel     <= n_wheel;
            r_o_rec     <= n_o_rec;
            r_o_play    <= n_o_play;
            r_o_count   <= n_o_count;
        end
    end

    // status count is reported modulo 256
    assign count_ext = {{STAT_W{1'b0}}, r_o_count};

    assign o_valid         = r_o_valid;
    assign o_report_valid  = r_report;
    assign o_out_buttons   = r_buttons;
    assign o_out_dx        = r_dx;
    assign o_out_dy        = r_dy;
    assign o_out_wheel     = r_wheel;
    assign o_is_recording  = r_o_rec;
    assign o_is_playing    = r_o_play;
    assign o_events_stored = count_ext[STAT_W-1:0];

endmodule
